/* src/xadp_pkg.sv */
// Shared types, constants and helpers for the XOR archive directory parser.
package xadp_pkg;

	localparam int KeyBytesDefault = 8;

	// Configuration port
	localparam int AddrWidth = 4;
	localparam logic RegKeyBytes  = 1'b0;
	localparam logic RegKeyLength = 1'b1;

	// Archive format
	localparam logic [31:0] ArchiveMagic = 32'hBAC0_4AC0;
	localparam logic [7:0]  Backslash    = 8'h5C;
	localparam logic [7:0]  Slash        = 8'h2F;

	// Result codes
	localparam logic [1:0] EndFlagSeen = 2'd0;
	localparam logic [1:0] EndTrunc    = 2'd1;
	localparam logic [1:0] ErrMagic    = 2'd0;
	localparam logic [1:0] ErrVersion  = 2'd1;
	localparam logic [1:0] ErrShort    = 2'd2;

	// Result queue
	localparam int QDepth = 4;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);

	typedef enum logic [1:0] {
		KIND_NAME,
		KIND_ENTRY,
		KIND_END,
		KIND_ERROR
	} kind_t;

	typedef enum logic [2:0] {
		PH_MAGIC,
		PH_VERSION,
		PH_FLAG,
		PH_NAMELEN,
		PH_NAME,
		PH_SIZE,
		PH_TIME,
		PH_DONE
	} phase_t;

	typedef struct packed {
		kind_t              kind;
		logic [7:0]         name_char;
		logic [7:0]         key_char;
		logic [31:0]        entry_index;
		logic signed [31:0] entry_size;
		logic signed [63:0] entry_time;
		logic [31:0]        entry_start;
		logic [31:0]        header_length;
		logic [1:0]         code;
		logic               final_res;
	} result_t;

	function automatic logic [7:0] to_upper(input logic [7:0] c);
		logic [7:0] u;
		u = c;
		if (c >= 8'h61 && c <= 8'h7A) begin
			u = c - 8'h20;
		end
		return u;
	endfunction

endpackage

/* src/xadp_parse.sv */
// Input register, decryption and parse state: one byte per cycle unless stalled.
module xadp_parse #(
	parameter int KEY_BYTES = xadp_pkg::KeyBytesDefault
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	output logic              byte_stall,
	input  logic [7:0]        raw_byte,
	input  logic              last_byte,
	input  logic [63:0]       key_bytes,
	input  logic [3:0]        key_length,
	input  logic              space_ok,
	output logic              push0,
	output logic              push1,
	output xadp_pkg::result_t res0,
	output xadp_pkg::result_t res1
);

	localparam logic [3:0] KlenMax = 4'(KEY_BYTES);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       proc;

	xadp_pkg::phase_t phase_q, phase_d;
	logic [3:0]  fcnt_q, fcnt_d;
	logic [2:0]  kpos_q, kpos_d;
	logic [31:0] off_q, off_d;
	logic [63:0] shift_q, shift_d;
	logic [31:0] held_q, held_d;
	logic [7:0]  nrem_q, nrem_d;
	logic [31:0] start_q, start_d;
	logic [31:0] cnt_q, cnt_d;

	logic [3:0]  klen;
	logic [3:0]  kpos_inc;
	logic [7:0]  b;
	logic [7:0]  c;
	logic [3:0]  fcnt_inc;
	logic [63:0] sh_ins4;
	logic [63:0] sh_ins8;
	logic [7:0]  nrem_dec;
	logic        p_valid;
	logic        e_valid;
	xadp_pkg::result_t p;
	xadp_pkg::result_t e;

	assign proc       = valid_s1 && space_ok;
	assign byte_stall = valid_s1 && !space_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			byte_s1 <= raw_byte;
			last_s1 <= last_byte;
		end
	end

	always_comb begin
		klen     = (key_length > KlenMax) ? KlenMax : key_length;
		kpos_inc = {1'b0, kpos_q} + 4'd1;
		b        = byte_s1;
		kpos_d   = kpos_q;
		if (klen != 4'd0) begin
			b      = byte_s1 ^ key_bytes[{kpos_q, 3'b000} +: 8];
			kpos_d = (kpos_inc >= klen) ? 3'd0 : kpos_inc[2:0];
		end
		off_d    = off_q + 32'd1;
		fcnt_inc = fcnt_q + 4'd1;
		sh_ins4  = shift_q | (64'(b) << {fcnt_q[1:0], 3'b000});
		sh_ins8  = shift_q | (64'(b) << {fcnt_q[2:0], 3'b000});
		nrem_dec = nrem_q - 8'd1;
		c        = (b == xadp_pkg::Backslash) ? xadp_pkg::Slash : b;

		phase_d = phase_q;
		fcnt_d  = fcnt_q;
		shift_d = shift_q;
		held_d  = held_q;
		nrem_d  = nrem_q;
		start_d = start_q;
		cnt_d   = cnt_q;
		p_valid = 1'b0;
		p       = '0;
		e_valid = 1'b0;
		e       = '0;

		unique case (phase_q) inside
			xadp_pkg::PH_MAGIC, xadp_pkg::PH_VERSION: begin
				shift_d = sh_ins4;
				fcnt_d  = fcnt_inc;
				if (fcnt_inc >= 4'd4) begin
					shift_d = '0;
					fcnt_d  = '0;
					if (phase_q == xadp_pkg::PH_MAGIC) begin
						if (sh_ins4[31:0] != xadp_pkg::ArchiveMagic) begin
							p_valid = 1'b1;
							p.code  = xadp_pkg::ErrMagic;
							phase_d = xadp_pkg::PH_DONE;
						end else begin
							phase_d = xadp_pkg::PH_VERSION;
						end
					end else begin
						if (sh_ins4[31:0] != 32'd0) begin
							p_valid = 1'b1;
							p.code  = xadp_pkg::ErrVersion;
							phase_d = xadp_pkg::PH_DONE;
						end else begin
							phase_d = xadp_pkg::PH_FLAG;
						end
					end
				end
				// A header cut short reports once, unless a bad field already did.
				if (last_s1 && (phase_d == xadp_pkg::PH_MAGIC ||
				    phase_d == xadp_pkg::PH_VERSION)) begin
					p_valid = 1'b1;
					p.code  = xadp_pkg::ErrShort;
					phase_d = xadp_pkg::PH_DONE;
				end
				if (p_valid) begin
					p.kind          = xadp_pkg::KIND_ERROR;
					p.header_length = off_d;
				end
			end
			xadp_pkg::PH_FLAG: begin
				if (b[7]) begin
					p_valid         = 1'b1;
					p.kind          = xadp_pkg::KIND_END;
					p.entry_index   = cnt_q;
					p.header_length = off_d;
					p.code          = xadp_pkg::EndFlagSeen;
					phase_d         = xadp_pkg::PH_DONE;
				end else begin
					phase_d = xadp_pkg::PH_NAMELEN;
				end
			end
			xadp_pkg::PH_NAMELEN: begin
				nrem_d  = b;
				phase_d = (b == 8'd0) ? xadp_pkg::PH_SIZE : xadp_pkg::PH_NAME;
			end
			xadp_pkg::PH_NAME: begin
				p_valid       = 1'b1;
				p.kind        = xadp_pkg::KIND_NAME;
				p.name_char   = c;
				p.key_char    = xadp_pkg::to_upper(c);
				p.entry_index = cnt_q;
				nrem_d        = nrem_dec;
				if (nrem_dec == 8'd0) begin
					phase_d = xadp_pkg::PH_SIZE;
				end
			end
			xadp_pkg::PH_SIZE: begin
				shift_d = sh_ins4;
				fcnt_d  = fcnt_inc;
				if (fcnt_inc >= 4'd4) begin
					held_d  = sh_ins4[31:0];
					shift_d = '0;
					fcnt_d  = '0;
					phase_d = xadp_pkg::PH_TIME;
				end
			end
			xadp_pkg::PH_TIME: begin
				shift_d = sh_ins8;
				fcnt_d  = fcnt_inc;
				if (fcnt_inc >= 4'd8) begin
					p_valid       = 1'b1;
					p.kind        = xadp_pkg::KIND_ENTRY;
					p.entry_index = cnt_q;
					p.entry_size  = held_q;
					p.entry_time  = sh_ins8;
					p.entry_start = start_q;
					start_d       = start_q + held_q;
					cnt_d         = cnt_q + 32'd1;
					shift_d       = '0;
					fcnt_d        = '0;
					phase_d       = xadp_pkg::PH_FLAG;
				end
			end
			default: begin
			end
		endcase

		if (last_s1) begin
			if (phase_d != xadp_pkg::PH_DONE) begin
				e_valid         = 1'b1;
				e.kind          = xadp_pkg::KIND_END;
				e.entry_index   = cnt_d;
				e.header_length = off_d;
				e.code          = xadp_pkg::EndTrunc;
			end
			// The next byte opens a new archive.
			phase_d = xadp_pkg::PH_MAGIC;
			fcnt_d  = '0;
			kpos_d  = '0;
			off_d   = '0;
			shift_d = '0;
			held_d  = '0;
			nrem_d  = '0;
			start_d = '0;
			cnt_d   = '0;
		end

		e.final_res = 1'b1;
		p.final_res = !e_valid;
		push0       = proc && (p_valid || e_valid);
		push1       = proc && p_valid && e_valid;
		res0        = p_valid ? p : e;
		res1        = e;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= xadp_pkg::PH_MAGIC;
			fcnt_q  <= '0;
			kpos_q  <= '0;
			off_q   <= '0;
			shift_q <= '0;
			held_q  <= '0;
			nrem_q  <= '0;
			start_q <= '0;
			cnt_q   <= '0;
		end else if (proc) begin
			phase_q <= phase_d;
			fcnt_q  <= fcnt_d;
			kpos_q  <= kpos_d;
			off_q   <= off_d;
			shift_q <= shift_d;
			held_q  <= held_d;
			nrem_q  <= nrem_d;
			start_q <= start_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

/* src/xadp_outq.sv */
// Result queue: up to two results in per cycle, one out unless stalled.
module xadp_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push0,
	input  logic              push1,
	input  xadp_pkg::result_t res0,
	input  xadp_pkg::result_t res1,
	output logic              space_ok,
	output logic              res_valid,
	input  logic              res_stall,
	output xadp_pkg::result_t head
);

	xadp_pkg::result_t mem_q [xadp_pkg::QDepth];
	logic [xadp_pkg::QPtrW-1:0] wr_q;
	logic [xadp_pkg::QPtrW-1:0] rd_q;
	logic [xadp_pkg::QCntW-1:0] cnt_q;
	logic [xadp_pkg::QPtrW-1:0] wr1;
	logic [xadp_pkg::QCntW-1:0] npush;
	logic                       pop;

	// Room for two results is needed before an item is processed.
	assign space_ok  = (cnt_q <= xadp_pkg::QCntW'(xadp_pkg::QDepth - 2));
	assign res_valid = (cnt_q != '0);
	assign pop       = res_valid && !res_stall;
	assign head      = mem_q[rd_q];
	assign wr1       = wr_q + 1'b1;
	assign npush     = xadp_pkg::QCntW'(push0) + xadp_pkg::QCntW'(push1);

	always_ff @(posedge clk) begin
		if (push0) begin
			mem_q[wr_q] <= res0;
		end
		if (push1) begin
			mem_q[wr1] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + xadp_pkg::QPtrW'(npush);
			rd_q  <= rd_q + xadp_pkg::QPtrW'(pop);
			cnt_q <= cnt_q + npush - xadp_pkg::QCntW'(pop);
		end
	end

endmodule

/* src/xor_archive_directory_parser.sv */
// Top level of the XOR archive directory parser with its configuration registers.
//
// The block takes one archive byte per cycle while byte_stall is low: each byte is
// registered, then decrypted and parsed from that register while the next byte is
// taken in. A byte gives zero, one or two results; they enter a four-entry result
// queue and leave one per cycle while res_stall is low. Only the final byte of an
// archive can give two results. Input is held off only while the result queue
// has fewer than two free entries.
// Write key_bytes (address 0) and key_length (address 8) while the block is idle;
// the key index restarts with each archive.
module xor_archive_directory_parser #(
	parameter int KEY_BYTES = xadp_pkg::KeyBytesDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [xadp_pkg::AddrWidth-1:0] paddr,
	input  logic [63:0]                   pwdata,
	output logic [63:0]                   prdata,
	output logic                          pready,
	input  logic                          byte_valid,
	output logic                          byte_stall,
	input  logic [7:0]                    raw_byte,
	input  logic                          last_byte,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [1:0]                    kind,
	output logic [7:0]                    name_char,
	output logic [7:0]                    key_char,
	output logic [31:0]                   entry_index,
	output logic signed [31:0]            entry_size,
	output logic signed [63:0]            entry_time,
	output logic [31:0]                   entry_start,
	output logic [31:0]                   header_length,
	output logic [1:0]                    code,
	output logic                          final_res
);

	logic [63:0] key_bytes_q;
	logic [3:0]  key_length_q;
	logic        cfg_wr;
	logic        space_ok;
	logic        push0;
	logic        push1;
	xadp_pkg::result_t res0;
	xadp_pkg::result_t res1;
	xadp_pkg::result_t head;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_bytes_q  <= '0;
			key_length_q <= '0;
		end else if (cfg_wr) begin
			if (paddr[3] == xadp_pkg::RegKeyLength) begin
				key_length_q <= pwdata[3:0];
			end else begin
				key_bytes_q <= pwdata;
			end
		end
	end

	always_comb begin
		unique case (paddr[3])
			xadp_pkg::RegKeyBytes:  prdata = key_bytes_q;
			xadp_pkg::RegKeyLength: prdata = {60'd0, key_length_q};
			default:                prdata = '0;
		endcase
	end

	xadp_parse #(
		.KEY_BYTES(KEY_BYTES)
	) u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.raw_byte   (raw_byte),
		.last_byte  (last_byte),
		.key_bytes  (key_bytes_q),
		.key_length (key_length_q),
		.space_ok   (space_ok),
		.push0      (push0),
		.push1      (push1),
		.res0       (res0),
		.res1       (res1)
	);

	xadp_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push0     (push0),
		.push1     (push1),
		.res0      (res0),
		.res1      (res1),
		.space_ok  (space_ok),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.head      (head)
	);

	assign kind          = head.kind;
	assign name_char     = head.name_char;
	assign key_char      = head.key_char;
	assign entry_index   = head.entry_index;
	assign entry_size    = head.entry_size;
	assign entry_time    = head.entry_time;
	assign entry_start   = head.entry_start;
	assign header_length = head.header_length;
	assign code          = head.code;
	assign final_res     = head.final_res;

endmodule

/* src/xadp_checker.sv */
// Port-level checks on the result channel of the parser, bound to the top level.
module xadp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_stall,
	input logic [1:0]  kind,
	input logic [7:0]  name_char,
	input logic [7:0]  key_char,
	input logic [31:0] entry_index,
	input logic [31:0] header_length,
	input logic [1:0]  code
);

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result valid dropped while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(kind) && $stable(entry_index) &&
		$stable(header_length))
		else $error("stalled result changed");

	a_name_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == xadp_pkg::KIND_NAME |-> code == 2'd0 &&
		header_length == 32'd0)
		else $error("name byte carries end or error fields");

	a_entry_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == xadp_pkg::KIND_ENTRY |-> name_char == 8'd0 &&
		key_char == 8'd0 && header_length == 32'd0)
		else $error("entry record carries name or length fields");

	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == xadp_pkg::KIND_ERROR |-> entry_index == 32'd0 &&
		code != 2'd3 && header_length != 32'd0)
		else $error("header error is malformed");

endmodule

bind xor_archive_directory_parser xadp_checker u_xadp_checker (.*);

/* test/tb.sv */
// Self-checking testbench for the XOR archive directory parser: random archives against a predictor.
`timescale 1ns / 100ps

import xadp_pkg::*;

class directory_tracker;
	logic [63:0] key_bytes;
	logic [3:0]  key_len;
	phase_t      phase;
	int unsigned fcount;
	logic [2:0]  kpos;
	logic [31:0] offset;
	logic [63:0] shift;
	logic [31:0] held_size;
	logic [7:0]  name_left;
	logic [31:0] run_start;
	logic [31:0] n_entries;
	result_t     due_records[$];
	int          mismatch_count;
	int          live_bytes;

	function new();
		key_bytes = '0;
		key_len = '0;
		mismatch_count = 0;
		live_bytes = 0;
		clear();
	endfunction

	function void clear();
		phase = PH_MAGIC;
		fcount = 0;
		kpos = '0;
		offset = '0;
		shift = '0;
		held_size = '0;
		name_left = '0;
		run_start = '0;
		n_entries = '0;
	endfunction

	function int eff_len();
		return (key_len > KeyBytesDefault) ? KeyBytesDefault : int'(key_len);
	endfunction

	// Key byte that the next accepted item will be XORed with.
	function logic [7:0] next_key();
		if (eff_len() == 0) begin
			return 8'h00;
		end
		return key_bytes[8*kpos +: 8];
	endfunction

	function result_t end_rec(logic [1:0] c);
		result_t r;
		r = '0;
		r.kind = KIND_END;
		r.entry_index = n_entries;
		r.header_length = offset;
		r.code = c;
		phase = PH_DONE;
		return r;
	endfunction

	function result_t error_rec(logic [1:0] c);
		result_t r;
		r = '0;
		r.kind = KIND_ERROR;
		r.header_length = offset;
		r.code = c;
		phase = PH_DONE;
		return r;
	endfunction

	function void take_byte(logic [7:0] raw, logic last);
		result_t     outs[$];
		result_t     r;
		logic [7:0]  b;
		logic [7:0]  c;
		logic [31:0] v;
		int          klen;
		b = raw;
		klen = eff_len();
		if (phase != PH_DONE) begin
			live_bytes++;
		end
		if (klen != 0) begin
			b = raw ^ key_bytes[8*kpos +: 8];
			// A position left beyond a shortened key is used once, then wraps.
			if (int'(kpos) + 1 >= klen) begin
				kpos = 3'd0;
			end else begin
				kpos = kpos + 3'd1;
			end
		end
		offset = offset + 32'd1;
		case (phase)
			PH_MAGIC, PH_VERSION: begin
				shift = shift | ({56'd0, b} << (8 * (fcount % 4)));
				fcount++;
				if (fcount >= 4) begin
					v = shift[31:0];
					shift = '0;
					fcount = 0;
					if (phase == PH_MAGIC) begin
						if (v != ArchiveMagic) begin
							outs.push_back(error_rec(ErrMagic));
						end else begin
							phase = PH_VERSION;
						end
					end else begin
						if (v != 32'd0) begin
							outs.push_back(error_rec(ErrVersion));
						end else begin
							phase = PH_FLAG;
						end
					end
				end
				if (last && (phase == PH_MAGIC || phase == PH_VERSION)) begin
					outs.push_back(error_rec(ErrShort));
				end
			end
			PH_FLAG: begin
				if (b[7]) begin
					outs.push_back(end_rec(EndFlagSeen));
				end else begin
					phase = PH_NAMELEN;
				end
			end
			PH_NAMELEN: begin
				name_left = b;
				phase = (b == 8'd0) ? PH_SIZE : PH_NAME;
			end
			PH_NAME: begin
				c = (b == Backslash) ? Slash : b;
				r = '0;
				r.kind = KIND_NAME;
				r.name_char = c;
				r.key_char = (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
				r.entry_index = n_entries;
				outs.push_back(r);
				name_left = name_left - 8'd1;
				if (name_left == 8'd0) begin
					phase = PH_SIZE;
				end
			end
			PH_SIZE: begin
				shift = shift | ({56'd0, b} << (8 * (fcount % 4)));
				fcount++;
				if (fcount >= 4) begin
					held_size = shift[31:0];
					shift = '0;
					fcount = 0;
					phase = PH_TIME;
				end
			end
			PH_TIME: begin
				shift = shift | ({56'd0, b} << (8 * (fcount % 8)));
				fcount++;
				if (fcount >= 8) begin
					r = '0;
					r.kind = KIND_ENTRY;
					r.entry_index = n_entries;
					r.entry_size = held_size;
					r.entry_time = shift;
					r.entry_start = run_start;
					outs.push_back(r);
					run_start = run_start + held_size;
					n_entries = n_entries + 32'd1;
					shift = '0;
					fcount = 0;
					phase = PH_FLAG;
				end
			end
			default: begin
			end
		endcase
		if (last) begin
			if (phase != PH_DONE) begin
				outs.push_back(end_rec(EndTrunc));
			end
			clear();
		end
		if (outs.size() > 0) begin
			outs[outs.size() - 1].final_res = 1'b1;
		end
		foreach (outs[i]) begin
			due_records.push_back(outs[i]);
		end
	endfunction

	task report_mismatch(string what);
		$display("mismatch at %0t: %s", $time, what);
		mismatch_count++;
	endtask

	task check_field(string name, logic [63:0] got, logic [63:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
		end
	endtask

	task match_record(result_t got);
		result_t want;
		if (due_records.size() == 0) begin
			report_mismatch($sformatf("result of kind %0d with nothing expected", got.kind));
			return;
		end
		want = due_records.pop_front();
		check_field("kind", got.kind, want.kind);
		check_field("name_char", got.name_char, want.name_char);
		check_field("key_char", got.key_char, want.key_char);
		check_field("entry_index", got.entry_index, want.entry_index);
		check_field("entry_size", got.entry_size, want.entry_size);
		check_field("entry_time", got.entry_time, want.entry_time);
		check_field("entry_start", got.entry_start, want.entry_start);
		check_field("header_length", got.header_length, want.header_length);
		check_field("code", got.code, want.code);
		check_field("final_res", got.final_res, want.final_res);
	endtask
endclass

module tb;
	localparam int CycleLimit = 600_000;
	localparam logic [AddrWidth-1:0] AddrKeyBytes  = {RegKeyBytes, 3'b000};
	localparam logic [AddrWidth-1:0] AddrKeyLength = {RegKeyLength, 3'b000};

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [AddrWidth-1:0]  paddr;
	logic [63:0]           pwdata;
	logic [63:0]           prdata;
	logic                  pready;
	logic                  byte_valid;
	logic                  byte_stall;
	logic [7:0]            raw_byte;
	logic                  last_byte;
	logic                  res_valid;
	logic                  res_stall;
	logic [1:0]            kind;
	logic [7:0]            name_char;
	logic [7:0]            key_char;
	logic [31:0]           entry_index;
	logic signed [31:0]    entry_size;
	logic signed [63:0]    entry_time;
	logic [31:0]           entry_start;
	logic [31:0]           header_length;
	logic [1:0]            code;
	logic                  final_res;

	directory_tracker sb;
	logic [7:0]       arc[$];
	int               send_idle_pct;
	int               recv_idle_pct;
	int               hold_cycles;
	int               cycle_count;

	xor_archive_directory_parser u_dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && byte_valid && !byte_stall) begin
			sb.take_byte(raw_byte, last_byte);
		end
	end

	always @(posedge clk) begin : result_monitor
		result_t got;
		if (arst_n && res_valid && !res_stall) begin
			got.kind = kind_t'(kind);
			got.name_char = name_char;
			got.key_char = key_char;
			got.entry_index = entry_index;
			got.entry_size = entry_size;
			got.entry_time = entry_time;
			got.entry_start = entry_start;
			got.header_length = header_length;
			got.code = code;
			got.final_res = final_res;
			sb.match_record(got);
		end
	end

	// A long hold-off, when requested, overrides the random stalls.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			res_stall <= 1'b1;
			hold_cycles = hold_cycles - 1;
		end else begin
			res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	task automatic apb_write(logic [AddrWidth-1:0] addr, logic [63:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_key(logic [63:0] kb, logic [3:0] kl);
		apb_write(AddrKeyBytes, kb);
		sb.key_bytes = kb;
		apb_write(AddrKeyLength, {60'd0, kl});
		sb.key_len = kl;
	endtask

	task automatic random_key();
		logic [63:0] kb;
		int          r;
		r = $urandom_range(0, 9);
		kb = (r == 0) ? 64'd0 : (r == 1) ? '1 : {$urandom, $urandom};
		set_key(kb, 4'($urandom_range(0, 8)));
	endtask

	// Stops offering items and waits until every expected result has come.
	task automatic wait_quiet();
		@(negedge clk);
		byte_valid <= 1'b0;
		while (sb.due_records.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
	endtask

	// The plaintext byte is encrypted with the key byte the block will use for it.
	task automatic push_byte(logic [7:0] plain, logic last);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			@(negedge clk);
		end
		byte_valid <= 1'b1;
		raw_byte <= plain ^ sb.next_key();
		last_byte <= last;
		do @(posedge clk); while (byte_stall);
	endtask

	task automatic send_archive(int split_at, logic [3:0] split_len);
		int i;
		for (i = 0; i < arc.size(); i++) begin
			if (i == split_at) begin
				wait_quiet();
				set_key(sb.key_bytes, split_len);
			end
			push_byte(arc[i], i == arc.size() - 1);
		end
	endtask

	function automatic void put_le(logic [63:0] v, int n);
		int i;
		for (i = 0; i < n; i++) begin
			arc.push_back(v[8*i +: 8]);
		end
	endfunction

	function automatic void put_header();
		put_le(ArchiveMagic, 4);
		put_le(64'd0, 4);
	endfunction

	function automatic logic [7:0] name_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 20) begin
			return Backslash;
		end
		if (r < 45) begin
			return 8'h61 + 8'($urandom_range(0, 25));
		end
		if (r < 55) begin
			return ($urandom_range(0, 1) != 0) ? 8'h60 : 8'h7B;
		end
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic void put_entry();
		int r;
		int len;
		r = $urandom_range(0, 99);
		len = (r < 10) ? 0 : (r < 97) ? $urandom_range(1, 8) : $urandom_range(200, 255);
		arc.push_back(8'($urandom_range(0, 127)));
		arc.push_back(8'(len));
		repeat (len) arc.push_back(name_byte());
		r = $urandom_range(0, 9);
		put_le((r == 0) ? 64'h7FFF_FFFF : (r == 1) ? 64'h8000_0000 : {32'd0, $urandom}, 4);
		r = $urandom_range(0, 9);
		put_le((r == 0) ? 64'h7FFF_FFFF_FFFF_FFFF : (r == 1) ? 64'h8000_0000_0000_0000 :
			{$urandom, $urandom}, 8);
	endfunction

	task automatic random_archive();
		int          r;
		int          cut;
		int          split;
		logic [31:0] v;
		arc.delete();
		r = $urandom_range(0, 99);
		if (r < 72) begin
			put_header();
			repeat ($urandom_range(0, 4)) put_entry();
			arc.push_back(8'h80 | 8'($urandom_range(0, 127)));
			repeat ($urandom_range(0, 2)) arc.push_back(8'($urandom));
			if ($urandom_range(0, 99) < 30) begin
				cut = $urandom_range(1, arc.size());
				while (arc.size() > cut) begin
					void'(arc.pop_back());
				end
			end
		end else if (r < 80) begin
			v = ($urandom_range(0, 1) != 0) ? ArchiveMagic ^ (32'd1 << $urandom_range(0, 31))
				: $urandom;
			put_le({32'd0, v}, 4);
			repeat ($urandom_range(0, 3)) arc.push_back(8'($urandom));
		end else if (r < 88) begin
			v = $urandom;
			if (v == 32'd0) begin
				v = 32'd1;
			end
			put_le(ArchiveMagic, 4);
			put_le({32'd0, v}, 4);
			repeat ($urandom_range(0, 3)) arc.push_back(8'($urandom));
		end else begin
			repeat ($urandom_range(1, 12)) arc.push_back(8'($urandom));
		end
		split = ($urandom_range(0, 99) < 8) ? $urandom_range(0, arc.size() - 1) : -1;
		send_archive(split, 4'($urandom_range(0, 8)));
	endtask

	initial begin
		int ph;
		int target;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		byte_valid = 1'b0;
		raw_byte = '0;
		last_byte = 1'b0;
		res_stall = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_cycles = 0;
		cycle_count = 0;
		sb = new();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_key(64'd0, 4'd0);
		// Input ends in the middle of the magic.
		arc.delete();
		put_le(ArchiveMagic, 3);
		send_archive(-1, 4'd0);
		// A wrong magic completed on the final byte wins over the short header.
		arc.delete();
		put_le(64'd0, 4);
		send_archive(-1, 4'd0);
		wait_quiet();
		set_key('1, 4'd8);
		// Header only, then a bad version followed by an ignored byte.
		arc.delete();
		put_header();
		send_archive(-1, 4'd0);
		arc.delete();
		put_le(ArchiveMagic, 4);
		put_le(64'h8000_0000, 4);
		arc.push_back(8'hFF);
		send_archive(-1, 4'd0);
		wait_quiet();
		set_key(64'h0123_4567_89AB_CDEF, 4'd8);
		// Two entries, the second with an empty name; the key shrinks below its index.
		arc.delete();
		put_header();
		arc.push_back(8'h00);
		arc.push_back(8'd3);
		arc.push_back(8'h61);
		arc.push_back(Backslash);
		arc.push_back(8'h7A);
		put_le(64'h8000_0000, 4);
		put_le(64'h7FFF_FFFF_FFFF_FFFF, 8);
		arc.push_back(8'h7F);
		arc.push_back(8'd0);
		put_le(64'hFFFF_FFFF, 4);
		put_le(64'h8000_0000_0000_0000, 8);
		arc.push_back(8'hFF);
		arc.push_back(8'h00);
		send_archive(6, 4'd3);
		// Input ends inside a name: one name result, then the truncated end.
		arc.delete();
		put_header();
		arc.push_back(8'h01);
		arc.push_back(8'd2);
		arc.push_back(8'h41);
		send_archive(-1, 4'd0);

		for (ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 24 : (ph == 1) ? 69 : 0;
			recv_idle_pct = (ph == 0) ? 69 : (ph == 1) ? 24 : 0;
			target = sb.live_bytes + 630;
			wait_quiet();
			random_key();
			// The receiver holds off while items keep coming, so the block backs up.
			hold_cycles = 80;
			while (sb.live_bytes < target) begin
				if ($urandom_range(0, 99) < 15) begin
					wait_quiet();
					random_key();
				end
				random_archive();
			end
		end

		@(negedge clk);
		byte_valid <= 1'b0;
		while (sb.due_records.size() != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
		if (sb.mismatch_count == 0 && sb.due_records.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule

/* sim.f */
src/xadp_pkg.sv
src/xadp_parse.sv
src/xadp_outq.sv
src/xor_archive_directory_parser.sv
src/xadp_checker.sv
test/tb.sv
